@@ rtl/cttjw_pkg.sv @@
// Package for the compound text to Japanese wide character decoder.
// Holds parser mode codes, set codes, state and result types and the reset state.
// No dependencies.
package cttjw_pkg;

    localparam int COUNT_BITS = 16;

    localparam logic [3:0] M_GROUND = 4'd0;
    localparam logic [3:0] M_ESC    = 4'd1;
    localparam logic [3:0] M_CSI_P  = 4'd2;
    localparam logic [3:0] M_CSI_I  = 4'd3;
    localparam logic [3:0] M_PRIV_M = 4'd4;
    localparam logic [3:0] M_PRIV_L = 4'd5;
    localparam logic [3:0] M_SKIP   = 4'd6;
    localparam logic [3:0] M_TRAIL  = 4'd7;
    localparam logic [3:0] M_DRAIN  = 4'd8;

    localparam logic [9:0] SET_96     = 10'h100;
    localparam logic [9:0] SET_MB     = 10'h200;
    localparam logic [9:0] SET_ASCII  = 10'h042;
    localparam logic [9:0] SET_ROMAN  = 10'h04a;
    localparam logic [9:0] SET_KANA   = 10'h049;
    localparam logic [9:0] SET_LATIN1 = 10'h141;
    localparam logic [9:0] SET_KANJI  = 10'h242;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_NL  = 8'h0a;
    localparam logic [7:0] CH_ESC = 8'h1b;
    localparam logic [7:0] CH_CSI = 8'h9b;

    localparam logic [7:0] IC_G0_94  = 8'h28;
    localparam logic [7:0] IC_G1_94  = 8'h29;
    localparam logic [7:0] IC_G1_96  = 8'h2d;
    localparam logic [7:0] IC_MB     = 8'h24;
    localparam logic [7:0] IC_PRIV   = 8'h25;
    localparam logic [7:0] IC_PRIV_2 = 8'h2f;

    typedef struct packed {
        logic [3:0]            mode;
        logic [9:0]            g0_set;
        logic [9:0]            g1_set;
        logic [1:0]            inter_cnt;
        logic [7:0]            inter_first;
        logic [7:0]            inter_second;
        logic [9:0]            cur_set;
        logic [1:0]            trail_left;
        logic [6:0]            accum;
        logic [13:0]           skip_left;
        logic [COUNT_BITS-1:0] chars_seen;
    } t_state;

    typedef struct packed {
        logic        char_valid;
        logic [15:0] wide_char;
        logic        done_res;
        logic        error;
        logic [15:0] char_count;
    } t_result;

    function automatic t_state state_init();
        t_state s;
        s              = '0;
        s.mode         = M_GROUND;
        s.g0_set       = SET_ASCII;
        s.g1_set       = SET_LATIN1;
        return s;
    endfunction

endpackage

@@ rtl/compound_text_to_japanese_wide_top.sv @@
// Top level of the compound text to Japanese wide character decoder.
// Depends on cttjw_pkg and cttjw_decode.
//
// Usage:
//   Slave channel: one octet of compound text per item on s_axis tdata,
//   tlast marks the final octet of a string.
//   Master channel: a result item is sent for each decoded character, for
//   the final octet and for the first error. tdata carries the wide
//   character and the character count, tuser the char_valid and error
//   flags, tlast is done (final octet or error).
//   An accepted octet passes the input register, decode and the result
//   register before its result is shown to the receiver. Throughput is
//   one octet per cycle while no receiver stall holds the input register.
//   After an error, octets are dropped without result up to the final one.
//   Reset clears the parser to ASCII in G0 and Latin-1 right half in G1;
//   each string end does the same.
//   When the receiver stalls, the result register holds; octets that make
//   no result keep flowing, and one that needs the output waits in the
//   input register, which then deasserts tready.
module compound_text_to_japanese_wide_top import cttjw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,   // last_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [15:0] wide_char, [31:16] char_count
    output logic [1:0]  o_m_axis_tuser,   // [0] char_valid, [1] error
    output logic        o_m_axis_tlast    // done_res
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    t_state     r_state;
    t_state     n_state;
    logic       r_out_valid;
    t_result    r_out;
    t_result    n_out;
    logic       emit;
    logic       out_free;
    logic       fire;

    cttjw_decode u_decode (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_state  (n_state),
        .o_emit   (emit),
        .o_result (n_out)
    );

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign fire            = r_in_valid && (!emit || out_free);
    assign o_s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= state_init();
        end else if (fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.char_count, r_out.wide_char};
    assign o_m_axis_tuser  = {r_out.error, r_out.char_valid};
    assign o_m_axis_tlast  = r_out.done_res;

endmodule

@@ rtl/cttjw_decode.sv @@
// Next-state and result logic for one octet of compound text.
// Depends on cttjw_pkg.
module cttjw_decode import cttjw_pkg::*; (
    input  t_state     i_state,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_state     o_state,
    output logic       o_emit,
    output t_result    o_result
);

    t_state      n;
    logic        err;
    logic        have;
    logic [15:0] wc;
    logic [9:0]  gs;
    logic [6:0]  c;
    logic [13:0] skip_new;
    logic [32:0] cnt_ext;

    assign c  = i_byte[6:0];
    assign gs = i_byte[7] ? i_state.g1_set : i_state.g0_set;
    assign skip_new = i_state.skip_left | {7'd0, c};

    always_comb begin
        n    = i_state;
        err  = 1'b0;
        have = 1'b0;
        wc   = '0;
        if (i_state.mode != M_DRAIN) begin
            unique case (i_state.mode)
                M_ESC: begin
                    if (i_byte >= 8'h20 && i_byte <= 8'h2f) begin
                        if (i_state.inter_cnt == 2'd0) n.inter_first = i_byte;
                        else if (i_state.inter_cnt == 2'd1) n.inter_second = i_byte;
                        if (i_state.inter_cnt != 2'd3) n.inter_cnt = i_state.inter_cnt + 2'd1;
                    end else if (i_byte >= 8'h30 && i_byte <= 8'h7e) begin
                        n.mode = M_GROUND;
                        if (i_state.inter_cnt == 2'd1) begin
                            if (i_state.inter_first == IC_G0_94) n.g0_set = {2'b00, i_byte};
                            else if (i_state.inter_first == IC_G1_94)
                                n.g1_set = {2'b00, i_byte};
                            else if (i_state.inter_first == IC_G1_96)
                                n.g1_set = {2'b00, i_byte} | SET_96;
                        end else if (i_state.inter_cnt == 2'd2) begin
                            if (i_state.inter_first == IC_MB) begin
                                if (i_state.inter_second == IC_G0_94)
                                    n.g0_set = {2'b00, i_byte} | SET_MB;
                                else if (i_state.inter_second == IC_G1_94)
                                    n.g1_set = {2'b00, i_byte} | SET_MB;
                                else if (i_state.inter_second == IC_G1_96)
                                    n.g1_set = {2'b00, i_byte} | SET_MB | SET_96;
                            end else if (i_state.inter_first == IC_PRIV &&
                                         i_state.inter_second == IC_PRIV_2) begin
                                n.mode = M_PRIV_M;
                            end
                        end
                    end else begin
                        err = 1'b1;
                    end
                end
                M_CSI_P: begin
                    if (i_byte >= 8'h30 && i_byte <= 8'h3f) n.mode = M_CSI_P;
                    else if (i_byte >= 8'h20 && i_byte <= 8'h2f) n.mode = M_CSI_I;
                    else if (i_byte >= 8'h40 && i_byte <= 8'h7e) n.mode = M_GROUND;
                    else err = 1'b1;
                end
                M_CSI_I: begin
                    if (i_byte >= 8'h20 && i_byte <= 8'h2f) n.mode = M_CSI_I;
                    else if (i_byte >= 8'h40 && i_byte <= 8'h7e) n.mode = M_GROUND;
                    else err = 1'b1;
                end
                M_PRIV_M: begin
                    n.skip_left = {c, 7'd0};
                    n.mode      = M_PRIV_L;
                end
                M_PRIV_L: begin
                    n.skip_left = skip_new;
                    n.mode      = (skip_new == '0) ? M_GROUND : M_SKIP;
                end
                M_SKIP: begin
                    if (i_state.skip_left != '0) n.skip_left = i_state.skip_left - 14'd1;
                    if (n.skip_left == '0) n.mode = M_GROUND;
                end
                M_TRAIL: begin
                    if (i_state.trail_left != '0) n.trail_left = i_state.trail_left - 2'd1;
                    if (n.trail_left == '0) begin
                        n.mode = M_GROUND;
                        if (i_state.cur_set == SET_KANJI) begin
                            have = 1'b1;
                            wc   = {1'b1, i_state.accum, 1'b1, c};
                        end
                    end
                end
                default: begin
                    n.mode = M_GROUND;
                    if (i_byte == CH_NL || i_byte == CH_TAB) begin
                        have = 1'b1;
                        wc   = {8'd0, i_byte};
                    end else if (i_byte == CH_CSI) begin
                        n.mode = M_CSI_P;
                    end else if (i_byte == CH_ESC) begin
                        n.mode         = M_ESC;
                        n.inter_cnt    = '0;
                        n.inter_first  = '0;
                        n.inter_second = '0;
                    end else if (i_byte[6:5] == 2'b00) begin
                        err = 1'b1;
                    end else if ((gs & SET_MB) != '0) begin
                        unique case (gs[6:4])
                            3'd7:       n.trail_left = 2'd3;
                            3'd6:       n.trail_left = 2'd2;
                            3'd4, 3'd5: n.trail_left = 2'd1;
                            default:    err = 1'b1;
                        endcase
                        if (!err) begin
                            n.cur_set = gs;
                            n.accum   = c;
                            n.mode    = M_TRAIL;
                        end
                    end else if (gs == SET_ASCII || gs == SET_ROMAN) begin
                        have = 1'b1;
                        wc   = {9'd0, c};
                    end else if (gs == SET_KANA) begin
                        have = 1'b1;
                        wc   = {8'd0, 1'b1, c};
                    end
                end
            endcase
            if (!err && i_last && n.mode != M_GROUND) err = 1'b1;
            if (have && n.chars_seen != '1) n.chars_seen = n.chars_seen + COUNT_BITS'(1);
        end
    end

    assign cnt_ext = 33'(n.chars_seen);

    always_comb begin
        o_emit              = (i_state.mode != M_DRAIN) && (err || i_last || have);
        o_result.char_valid = have && !err;
        o_result.wide_char  = (have && !err) ? wc : 16'd0;
        o_result.done_res   = err || i_last;
        o_result.error      = err;
        o_result.char_count = (cnt_ext > 33'h0ffff) ? 16'hffff : cnt_ext[15:0];
        if (i_last) begin
            o_state = state_init();
        end else if (err) begin
            o_state      = n;
            o_state.mode = M_DRAIN;
        end else begin
            o_state = n;
        end
    end

endmodule

@@ rtl/cttjw_checker.sv @@
// Port-level checks for the compound text decoder top level, bound to it.
// Depends on compound_text_to_japanese_wide_top.
module cttjw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    a_err_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1] |-> o_m_axis_tlast)
        else $error("error item without done");

    a_err_nochar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1] |-> !o_m_axis_tuser[0])
        else $error("error item carries a character");

    a_zero_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata[15:0] == 16'd0)
        else $error("nonzero wide char without char_valid");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata[31:16] != 16'd0)
        else $error("decoded character with zero count");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled item changed");

endmodule

bind compound_text_to_japanese_wide_top cttjw_checker u_cttjw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

@@ sim/testbench.sv @@
// Self-checking testbench for compound_text_to_japanese_wide_top.
// Drives compound text octets and predicts the wide characters, done and error flags.
// A directed table runs first, then random strings, the last stretch at full rate.
// Depends on cttjw_pkg and the decoder RTL.
module testbench;
    import cttjw_pkg::*;

    localparam int RANDOM_ITEMS    = 1900;
    localparam int FULL_RATE_ITEMS = 200;
    localparam int STUCK_LIMIT     = 2000;

    typedef struct packed {
        logic [7:0] octet;
        logic       fin;
        logic       pinned;
        t_result    want;
    } t_row;

    localparam t_result NO_RES  = '0;

    // pinned rows carry the result typed in, the others use the predictor
    localparam t_row DIRECTED [25] = '{
        {8'h41,            1'b0, 1'b1, {1'b1, 16'h0041, 1'b0, 1'b0, 16'd1}},
        {CH_TAB,           1'b0, 1'b0, NO_RES},
        {CH_ESC,           1'b0, 1'b0, NO_RES},
        {IC_G1_94,         1'b0, 1'b0, NO_RES},
        {SET_KANA[7:0],    1'b0, 1'b0, NO_RES},
        {8'hff,            1'b0, 1'b0, NO_RES},
        {CH_ESC,           1'b0, 1'b0, NO_RES},
        {IC_MB,            1'b0, 1'b0, NO_RES},
        {IC_G0_94,         1'b0, 1'b0, NO_RES},
        {SET_KANJI[7:0],   1'b0, 1'b0, NO_RES},
        {8'h7f,            1'b0, 1'b0, NO_RES},
        {8'h80,            1'b0, 1'b0, NO_RES},
        {CH_CSI,           1'b0, 1'b0, NO_RES},
        {8'h6d,            1'b0, 1'b0, NO_RES},
        {CH_NL,            1'b1, 1'b1, {1'b1, 16'h000a, 1'b1, 1'b0, 16'd5}},
        {8'h00,            1'b0, 1'b1, {1'b0, 16'h0000, 1'b1, 1'b1, 16'd0}},
        {8'h41,            1'b1, 1'b0, NO_RES},
        {CH_ESC,           1'b0, 1'b0, NO_RES},
        {IC_PRIV,          1'b0, 1'b0, NO_RES},
        {IC_PRIV_2,        1'b0, 1'b0, NO_RES},
        {8'h40,            1'b0, 1'b0, NO_RES},
        {8'h80,            1'b0, 1'b0, NO_RES},
        {8'h01,            1'b0, 1'b0, NO_RES},
        {8'h41,            1'b0, 1'b0, NO_RES},
        {CH_ESC,           1'b1, 1'b1, {1'b0, 16'h0000, 1'b1, 1'b1, 16'd0}}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;   // [7:0] data_byte
    logic        i_s_axis_tlast;   // last_byte
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;   // [15:0] wide_char, [31:16] char_count
    logic [1:0]  o_m_axis_tuser;   // [0] char_valid, [1] error
    logic        o_m_axis_tlast;   // done_res

    compound_text_to_japanese_wide_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // decoder state as predicted
    logic [3:0]            dec_mode;
    logic [9:0]            dec_g0;
    logic [9:0]            dec_g1;
    logic [1:0]            dec_icnt;
    logic [7:0]            dec_i1;
    logic [7:0]            dec_i2;
    logic [9:0]            dec_cur;
    logic [1:0]            dec_trail;
    logic [6:0]            dec_lead;
    logic [13:0]           dec_skip;
    logic [COUNT_BITS-1:0] dec_count;

    t_result    decoded_q[$];
    logic [7:0] text_q[$];
    int         mismatch_count = 0;
    int         live_items = 0;
    int         stuck_cycles = 0;
    int         rx_hold = 0;
    bit         tx_idle;
    bit         rx_idle;

    function automatic void clear_decoder();
        dec_mode  = M_GROUND;
        dec_g0    = SET_ASCII;
        dec_g1    = SET_LATIN1;
        dec_icnt  = '0;
        dec_i1    = '0;
        dec_i2    = '0;
        dec_cur   = '0;
        dec_trail = '0;
        dec_lead  = '0;
        dec_skip  = '0;
        dec_count = '0;
    endfunction

    function automatic bit decode_octet(input logic [7:0] b, input logic fin,
                                        output t_result r);
        logic        err;
        logic        have;
        logic [15:0] wc;
        logic [9:0]  gs;
        err  = 1'b0;
        have = 1'b0;
        wc   = '0;
        r    = '0;
        if (dec_mode == M_DRAIN) begin
            if (fin) clear_decoder();
            return 1'b0;
        end
        case (dec_mode)
            M_ESC: begin
                if (b inside {[8'h20:8'h2f]}) begin
                    if (dec_icnt == 2'd0) dec_i1 = b;
                    else if (dec_icnt == 2'd1) dec_i2 = b;
                    if (dec_icnt < 2'd3) dec_icnt++;
                end else if (b inside {[8'h30:8'h7e]}) begin
                    dec_mode = M_GROUND;
                    if (dec_icnt == 2'd1) begin
                        if (dec_i1 == IC_G0_94) dec_g0 = {2'b00, b};
                        else if (dec_i1 == IC_G1_94) dec_g1 = {2'b00, b};
                        else if (dec_i1 == IC_G1_96) dec_g1 = {2'b00, b} | SET_96;
                    end else if (dec_icnt == 2'd2) begin
                        if (dec_i1 == IC_MB) begin
                            if (dec_i2 == IC_G0_94) dec_g0 = {2'b00, b} | SET_MB;
                            else if (dec_i2 == IC_G1_94) dec_g1 = {2'b00, b} | SET_MB;
                            else if (dec_i2 == IC_G1_96)
                                dec_g1 = {2'b00, b} | SET_MB | SET_96;
                        end else if (dec_i1 == IC_PRIV && dec_i2 == IC_PRIV_2) begin
                            dec_mode = M_PRIV_M;
                        end
                    end
                end else begin
                    err = 1'b1;
                end
            end
            M_CSI_P: begin
                if (b inside {[8'h30:8'h3f]}) dec_mode = M_CSI_P;
                else if (b inside {[8'h20:8'h2f]}) dec_mode = M_CSI_I;
                else if (b inside {[8'h40:8'h7e]}) dec_mode = M_GROUND;
                else err = 1'b1;
            end
            M_CSI_I: begin
                if (b inside {[8'h20:8'h2f]}) dec_mode = M_CSI_I;
                else if (b inside {[8'h40:8'h7e]}) dec_mode = M_GROUND;
                else err = 1'b1;
            end
            M_PRIV_M: begin
                dec_skip = {b[6:0], 7'd0};
                dec_mode = M_PRIV_L;
            end
            M_PRIV_L: begin
                dec_skip = dec_skip | {7'd0, b[6:0]};
                dec_mode = (dec_skip == '0) ? M_GROUND : M_SKIP;
            end
            M_SKIP: begin
                if (dec_skip != '0) dec_skip--;
                if (dec_skip == '0) dec_mode = M_GROUND;
            end
            M_TRAIL: begin
                if (dec_trail != '0) dec_trail--;
                if (dec_trail == '0) begin
                    dec_mode = M_GROUND;
                    if (dec_cur == SET_KANJI) begin
                        have = 1'b1;
                        wc   = 16'h8080 | {1'b0, dec_lead, 1'b0, b[6:0]};
                    end
                end
            end
            default: begin
                dec_mode = M_GROUND;
                if (b == CH_NL || b == CH_TAB) begin
                    have = 1'b1;
                    wc   = {8'h00, b};
                end else if (b == CH_CSI) begin
                    dec_mode = M_CSI_P;
                end else if (b == CH_ESC) begin
                    dec_mode = M_ESC;
                    dec_icnt = '0;
                    dec_i1   = '0;
                    dec_i2   = '0;
                end else if (b[6:5] == 2'b00) begin
                    err = 1'b1;
                end else begin
                    gs = b[7] ? dec_g1 : dec_g0;
                    if ((gs & SET_MB) != '0) begin
                        case (gs[6:4])
                            3'h7:       dec_trail = 2'd3;
                            3'h6:       dec_trail = 2'd2;
                            3'h4, 3'h5: dec_trail = 2'd1;
                            default:    err = 1'b1;
                        endcase
                        if (!err) begin
                            dec_cur  = gs;
                            dec_lead = b[6:0];
                            dec_mode = M_TRAIL;
                        end
                    end else if (gs == SET_ASCII || gs == SET_ROMAN) begin
                        have = 1'b1;
                        wc   = {9'd0, b[6:0]};
                    end else if (gs == SET_KANA) begin
                        have = 1'b1;
                        wc   = {8'h00, 1'b1, b[6:0]};
                    end
                end
            end
        endcase
        if (!err && fin && dec_mode != M_GROUND) err = 1'b1;
        if (have && dec_count != '1) dec_count++;
        if (!err && !fin && !have) return 1'b0;
        r.char_valid = have && !err;
        r.wide_char  = (have && !err) ? wc : 16'h0000;
        r.done_res   = err || fin;
        r.error      = err;
        r.char_count = (dec_count > 'hffff) ? 16'hffff : 16'(dec_count);
        if (fin) clear_decoder();
        else if (err) dec_mode = M_DRAIN;
        return 1'b1;
    endfunction

    task automatic put_octet(input logic [7:0] b, input logic fin, input logic pinned,
                             input t_result want);
        t_result r;
        bit      has;
        if (tx_idle && $urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (dec_mode != M_DRAIN) live_items++;
        has = decode_octet(b, fin, r);
        if (pinned) begin
            has = 1'b1;
            r   = want;
        end
        if (has) decoded_q.push_back(r);
    endtask

    task automatic drain_outputs();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (decoded_q.size() != 0);
    endtask

    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold         <= rx_hold - 1;
            i_m_axis_tready <= (rx_hold == 1);
        end else if (i_rst_n && rx_idle && $urandom_range(0, 15) == 0) begin
            rx_hold         <= $urandom_range(1, 18);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.char_valid = o_m_axis_tuser[0];
            got.wide_char  = o_m_axis_tdata[15:0];
            got.done_res   = o_m_axis_tlast;
            got.error      = o_m_axis_tuser[1];
            got.char_count = o_m_axis_tdata[31:16];
            if (decoded_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected item: valid=%0b char=%h done=%0b err=%0b count=%0d",
                             got.char_valid, got.wide_char, got.done_res, got.error,
                             got.char_count);
            end else begin
                want = decoded_q.pop_front();
                if (got.char_valid !== want.char_valid || got.wide_char !== want.wide_char ||
                    got.done_res !== want.done_res || got.error !== want.error ||
                    got.char_count !== want.char_count) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp valid=%0b char=%h done=%0b err=%0b count=%0d,",
                                 want.char_valid, want.wide_char, want.done_res, want.error,
                                 want.char_count,
                                 " got valid=%0b char=%h done=%0b err=%0b count=%0d",
                                 got.char_valid, got.wide_char,
                                 got.done_res, got.error, got.char_count);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        int         cut;
        int         len;
        int         pick;
        logic [7:0] fb;
        logic [7:0] m_oct;
        logic [7:0] l_oct;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tlast  <= 1'b0;
        i_m_axis_tready <= 1'b0;
        rx_idle         <= 1'b1;
        tx_idle = 1'b1;
        clear_decoder();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        foreach (DIRECTED[i])
            put_octet(DIRECTED[i].octet, DIRECTED[i].fin, DIRECTED[i].pinned, DIRECTED[i].want);
        drain_outputs();

        live_items = 0;
        while (live_items < RANDOM_ITEMS) begin
            text_q.delete();
            if (live_items < RANDOM_ITEMS - FULL_RATE_ITEMS) begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle <= ($urandom_range(0, 3) != 0);
            end else begin
                // full rate on both sides
                tx_idle = 1'b0;
                rx_idle <= 1'b0;
            end
            repeat ($urandom_range(1, 8)) begin
                pick = $urandom_range(0, 99);
                if (pick < 30) begin
                    repeat ($urandom_range(1, 6)) begin
                        if ($urandom_range(0, 3) == 0)
                            text_q.push_back(8'($urandom_range(8'ha0, 8'hff)));
                        else
                            text_q.push_back(8'($urandom_range(8'h21, 8'h7e)));
                    end
                end else if (pick < 38) begin
                    text_q.push_back($urandom_range(0, 1) ? CH_NL : CH_TAB);
                end else if (pick < 50) begin
                    case ($urandom_range(0, 4))
                        0:       fb = SET_ASCII[7:0];
                        1:       fb = SET_ROMAN[7:0];
                        2:       fb = SET_KANA[7:0];
                        3:       fb = SET_LATIN1[7:0];
                        default: fb = 8'($urandom_range(8'h30, 8'h7e));
                    endcase
                    text_q.push_back(CH_ESC);
                    case ($urandom_range(0, 5))
                        0: text_q.push_back(IC_G0_94);
                        1: text_q.push_back(IC_G1_94);
                        2: text_q.push_back(IC_G1_96);
                        3: begin text_q.push_back(IC_MB); text_q.push_back(IC_G0_94); end
                        4: begin text_q.push_back(IC_MB); text_q.push_back(IC_G1_94); end
                        default: begin
                            text_q.push_back(IC_MB);
                            text_q.push_back(IC_G1_96);
                        end
                    endcase
                    text_q.push_back(fb);
                end else if (pick < 62) begin
                    // the sets the decoder emits
                    text_q.push_back(CH_ESC);
                    case ($urandom_range(0, 3))
                        0: begin
                            text_q.push_back(IC_MB);
                            text_q.push_back($urandom_range(0, 1) ? IC_G0_94 : IC_G1_94);
                            text_q.push_back(SET_KANJI[7:0]);
                        end
                        1: begin
                            text_q.push_back(IC_G0_94);
                            text_q.push_back(SET_ASCII[7:0]);
                        end
                        2: begin
                            text_q.push_back(IC_G0_94);
                            text_q.push_back(SET_ROMAN[7:0]);
                        end
                        default: begin
                            text_q.push_back($urandom_range(0, 1) ? IC_G0_94 : IC_G1_94);
                            text_q.push_back(SET_KANA[7:0]);
                        end
                    endcase
                end else if (pick < 72) begin
                    text_q.push_back(CH_CSI);
                    repeat ($urandom_range(0, 3))
                        text_q.push_back(8'($urandom_range(8'h30, 8'h3f)));
                    repeat ($urandom_range(0, 2))
                        text_q.push_back(8'($urandom_range(8'h20, 8'h2f)));
                    text_q.push_back(8'($urandom_range(8'h40, 8'h7e)));
                end else if (pick < 78) begin
                    m_oct = {1'($urandom_range(0, 1)), 7'd0};
                    if ($urandom_range(0, 19) == 0) m_oct[0] = 1'b1;
                    l_oct = {1'($urandom_range(0, 1)), 7'($urandom_range(0, 7))};
                    len   = {m_oct[6:0], l_oct[6:0]};
                    text_q.push_back(CH_ESC);
                    text_q.push_back(IC_PRIV);
                    text_q.push_back(IC_PRIV_2);
                    text_q.push_back(8'($urandom_range(8'h30, 8'h7e)));
                    text_q.push_back(m_oct);
                    text_q.push_back(l_oct);
                    repeat (len) text_q.push_back(8'($urandom_range(0, 255)));
                end else if (pick < 88) begin
                    // unknown or ignored escapes
                    text_q.push_back(CH_ESC);
                    repeat ($urandom_range(0, 4))
                        text_q.push_back(8'($urandom_range(8'h20, 8'h2f)));
                    text_q.push_back(8'($urandom_range(8'h30, 8'h7e)));
                end else begin
                    if ($urandom_range(0, 2) == 0)
                        text_q.push_back($urandom_range(0, 1) ? CH_ESC : CH_CSI);
                    text_q.push_back(8'($urandom_range(0, 255)));
                end
            end
            if ($urandom_range(0, 4) == 0 && text_q.size() > 1) begin
                cut = $urandom_range(0, text_q.size() - 2);
            end else begin
                fb = $urandom_range(0, 1) ? CH_NL : 8'($urandom_range(8'h21, 8'hff));
                text_q.push_back(fb);
                cut = text_q.size() - 1;
            end
            for (int i = 0; i <= cut; i++)
                put_octet(text_q[i], i == cut, 1'b0, NO_RES);
            if (tx_idle && $urandom_range(0, 9) == 0) drain_outputs();
        end

        i_s_axis_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && decoded_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
